// File: src/nfcd_pkg.sv
package nfcd_pkg;

    localparam int MAX_CARS   = 8;
    localparam int FLOOR_BITS = 8;
    localparam int CAR_IDX_W  = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
    localparam int CAR_ID_W   = 4;
    localparam int LOAD_W     = 4;
    localparam int AGE_W      = 16;
    localparam int ACT_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
    localparam logic [AGE_W-1:0]  AGE_MAX  = '1;

    // action codes
    localparam logic [ACT_W-1:0] ACT_STATUS  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FAULT   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_WARNING = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REQUEST = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TICK    = 3'd4;

    // health codes
    localparam logic [1:0] HEALTH_OK    = 2'd0;
    localparam logic [1:0] HEALTH_FAULT = 2'd1;
    localparam logic [1:0] HEALTH_WARN  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CARS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_HOLD = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]      action;
        logic [CAR_ID_W-1:0]   car_id;
        logic [FLOOR_BITS-1:0] car_floor;
        logic [FLOOR_BITS-1:0] request_floor;
        logic [FLOOR_BITS-1:0] target_floor;
    } t_in;

    typedef struct packed {
        logic                  assigned;
        logic [CAR_ID_W-1:0]   chosen_car;
        logic [FLOOR_BITS-1:0] move_floor;
    } t_out;

    typedef struct packed {
        logic capture;
        logic apply;
        logic scan_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic is_req;
        logic scan_none;
        logic scan_last;
    } t_sts;

endpackage

// File: src/nfcd_ctrl.sv
module nfcd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  nfcd_pkg::t_sts i_sts,
    output nfcd_pkg::t_cmd o_cmd
);
    import nfcd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_sts.is_req) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_IDLE;
                end else if (i_sts.scan_none) begin
                    n_state = S_COMMIT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: src/nfcd_dp.sv
module nfcd_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  nfcd_pkg::t_in                     i_in_data,
    input  logic                              i_cfg_we,
    input  logic [nfcd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nfcd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  nfcd_pkg::t_cmd                    i_cmd,
    output nfcd_pkg::t_sts                    o_sts,
    output nfcd_pkg::t_out                    o_out_data
);
    import nfcd_pkg::*;

    // configuration
    logic [CAR_ID_W-1:0] r_num_cars;
    logic [LOAD_W-1:0]   r_capacity;
    logic [AGE_W-1:0]    r_hold;

    // per-car state
    logic [FLOOR_BITS-1:0] r_pos    [MAX_CARS];
    logic [LOAD_W-1:0]     r_load   [MAX_CARS];
    logic [1:0]            r_health [MAX_CARS];
    logic                  r_warned [MAX_CARS];
    logic [AGE_W-1:0]      r_age    [MAX_CARS];

    // current item
    logic [ACT_W-1:0]      r_action;
    logic                  r_slot_ok;
    logic [FLOOR_BITS-1:0] r_floor;
    logic [FLOOR_BITS-1:0] r_req;
    logic [FLOOR_BITS-1:0] r_target;

    // scan
    logic [CAR_IDX_W-1:0]  r_idx;
    logic                  r_found;
    logic [CAR_IDX_W-1:0]  r_best;
    logic [FLOOR_BITS-1:0] r_best_d;
    logic [LOAD_W-1:0]     r_best_load;
    t_out                  r_out;

    logic [CAR_ID_W-1:0]   count;
    logic [CAR_ID_W-1:0]   id_m1;
    logic                  id_ok;
    logic [FLOOR_BITS-1:0] cur_pos;
    logic [FLOOR_BITS-1:0] car_dist;
    logic                  elig;
    logic                  better;

    assign count = (r_num_cars > CAR_ID_W'(MAX_CARS)) ? CAR_ID_W'(MAX_CARS) : r_num_cars;
    assign id_m1 = i_in_data.car_id - CAR_ID_W'(1);
    assign id_ok = (i_in_data.car_id != '0) && (i_in_data.car_id <= CAR_ID_W'(MAX_CARS));

    assign cur_pos  = r_pos[r_idx];
    assign car_dist = (cur_pos > r_req) ? (cur_pos - r_req) : (r_req - cur_pos);
    assign elig     = (r_health[r_idx] == HEALTH_OK) && (r_load[r_idx] < r_capacity);
    assign better   = elig && (!r_found || (car_dist < r_best_d));

    assign o_sts.is_req    = (r_action == ACT_REQUEST);
    assign o_sts.scan_none = (count == '0);
    assign o_sts.scan_last = ((CAR_ID_W'(r_idx) + CAR_ID_W'(1)) == count);
    assign o_out_data      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cars <= CAR_ID_W'(8);
            r_capacity <= LOAD_W'(4);
            r_hold     <= AGE_W'(5);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM_CARS:  r_num_cars <= i_cfg_data[CAR_ID_W-1:0];
                CFG_CAPACITY:  r_capacity <= i_cfg_data[LOAD_W-1:0];
                CFG_WARN_HOLD: r_hold     <= i_cfg_data[AGE_W-1:0];
                default: ;
            endcase
        end
    end

    // item capture and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action  <= i_in_data.action;
            r_slot_ok <= id_ok;
            r_floor   <= i_in_data.car_floor;
            r_req     <= i_in_data.request_floor;
            r_target  <= i_in_data.target_floor;
            r_idx     <= (i_in_data.action == ACT_REQUEST) ? '0 : id_m1[CAR_IDX_W-1:0];
            r_found   <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + CAR_IDX_W'(1);
            if (better) begin
                r_found     <= 1'b1;
                r_best      <= r_idx;
                r_best_d    <= car_dist;
                r_best_load <= r_load[r_idx];
            end
        end
        if (i_cmd.commit) begin
            if (r_found) begin
                r_out.assigned   <= 1'b1;
                r_out.chosen_car <= CAR_ID_W'(r_best) + CAR_ID_W'(1);
                r_out.move_floor <= r_target;
            end else begin
                r_out <= '0;
            end
        end
    end

    // car state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_CARS; k++) begin
                r_pos[k]    <= '0;
                r_load[k]   <= '0;
                r_health[k] <= HEALTH_OK;
                r_warned[k] <= 1'b0;
                r_age[k]    <= '0;
            end
        end else if (i_cmd.apply) begin
            case (r_action)
                ACT_STATUS: begin
                    if (r_slot_ok) begin
                        r_pos[r_idx] <= r_floor;
                        if (r_load[r_idx] != '0) begin
                            r_load[r_idx] <= r_load[r_idx] - LOAD_W'(1);
                        end
                        if (!r_warned[r_idx] || (r_age[r_idx] > r_hold)) begin
                            r_health[r_idx] <= HEALTH_OK;
                        end
                    end
                end
                ACT_FAULT: begin
                    if (r_slot_ok) begin
                        r_health[r_idx] <= HEALTH_FAULT;
                    end
                end
                ACT_WARNING: begin
                    if (r_slot_ok) begin
                        r_health[r_idx] <= HEALTH_WARN;
                        r_warned[r_idx] <= 1'b1;
                        r_age[r_idx]    <= '0;
                    end
                end
                ACT_TICK: begin
                    for (int k = 0; k < MAX_CARS; k++) begin
                        if (r_age[k] != AGE_MAX) begin
                            r_age[k] <= r_age[k] + AGE_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end else if (i_cmd.commit && r_found) begin
            if (r_best_load != LOAD_MAX) begin
                r_load[r_best] <= r_best_load + LOAD_W'(1);
            end
        end
    end

endmodule

// File: src/nearest_free_car_dispatcher_top.sv
// Nearest free car dispatcher.
// Input channel (i_in_valid / o_in_ready / i_in_data): one beat per event.
//   Action status, fault, warning or tick updates car state and gives no
//   result; a ride request gives exactly one result beat.
// Output channel (o_out_valid / i_out_ready / o_out_data): assigned flag,
//   chosen car (0 when none) and move floor (0 when none).
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   ready whenever out of reset; index 0 car count, 1 capacity, 2 warning
//   hold ticks. Write only while the block is idle.
// Steps: an event is accepted, then applied. A request is accepted,
//   then scans min(car count, 8) cars, one car per cycle through a
//   single compare unit, then commits: it registers the result and
//   bumps the winner's load.
// The result sits in an output register; the next item is accepted while
//   it waits. A further request stalls in its commit cycle until the
//   receiver takes the pending beat.
// Reset (synchronous, active low): cars at floor 0, empty, healthy, never
//   warned; registers return to 8 cars, capacity 4, hold 5; no beat taken.
module nearest_free_car_dispatcher_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  nfcd_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output nfcd_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [nfcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nfcd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import nfcd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = i_rst_n;

    nfcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    nfcd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_data  (o_out_data)
    );

endmodule

// File: verif/nfcd_move_checker.sv
`timescale 1ns / 1ps

// Watches all three channels and predicts the move result of each ride
// request, then compares the result beats against it in order.
module nfcd_move_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  nfcd_pkg::t_in                   i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  nfcd_pkg::t_out                  i_out_data,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [nfcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nfcd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_err_count,
    output int                              o_pending,
    output int                              o_checked
);
    import nfcd_pkg::*;

    localparam logic [CAR_ID_W-1:0] RST_NUM_CARS = 4'd8;
    localparam logic [LOAD_W-1:0]   RST_CAPACITY = 4'd4;
    localparam logic [AGE_W-1:0]    RST_HOLD     = 16'd5;
    localparam int                  REPORT_MAX   = 10;

    // mirrored car state and settings
    logic [FLOOR_BITS-1:0] floor_at   [MAX_CARS];
    logic [LOAD_W-1:0]     load_of    [MAX_CARS];
    logic [1:0]            health_of  [MAX_CARS];
    logic                  warned     [MAX_CARS];
    logic [AGE_W-1:0]      warn_age   [MAX_CARS];
    logic [CAR_ID_W-1:0]   cars_in_service;
    logic [LOAD_W-1:0]     capacity;
    logic [AGE_W-1:0]      hold_ticks;

    t_out expected_moves [$];
    int   mismatches = 0;
    int   compared   = 0;

    function automatic void apply_dispatch_beat(input t_in b);
        int                    slot;
        int                    scan_len;
        bit                    found;
        int                    best;
        logic [FLOOR_BITS-1:0] car_dist;
        logic [FLOOR_BITS-1:0] best_dist;
        t_out                  move;
        slot      = (b.car_id == 0 || b.car_id > MAX_CARS) ? -1 : int'(b.car_id) - 1;
        found     = 1'b0;
        best      = 0;
        best_dist = '0;
        move      = '0;
        case (b.action)
            ACT_STATUS: begin
                if (slot >= 0) begin
                    floor_at[slot] = b.car_floor;
                    if (load_of[slot] != '0)
                        load_of[slot] = load_of[slot] - 1'b1;
                    // a stale warning (or none at all) lets status restore the car
                    if (!warned[slot] || warn_age[slot] > hold_ticks)
                        health_of[slot] = HEALTH_OK;
                end
            end
            ACT_FAULT: begin
                if (slot >= 0)
                    health_of[slot] = HEALTH_FAULT;
            end
            ACT_WARNING: begin
                if (slot >= 0) begin
                    health_of[slot] = HEALTH_WARN;
                    warned[slot]    = 1'b1;
                    warn_age[slot]  = '0;
                end
            end
            ACT_TICK: begin
                for (int i = 0; i < MAX_CARS; i++)
                    if (warn_age[i] != AGE_MAX)
                        warn_age[i] = warn_age[i] + 1'b1;
            end
            ACT_REQUEST: begin
                scan_len = (cars_in_service > MAX_CARS) ? MAX_CARS : int'(cars_in_service);
                for (int i = 0; i < scan_len; i++) begin
                    if (health_of[i] == HEALTH_OK && load_of[i] < capacity) begin
                        car_dist = (floor_at[i] > b.request_floor)
                                   ? floor_at[i] - b.request_floor
                                   : b.request_floor - floor_at[i];
                        // strict compare keeps the lower car on a tie
                        if (!found || car_dist < best_dist) begin
                            found     = 1'b1;
                            best      = i;
                            best_dist = car_dist;
                        end
                    end
                end
                if (found) begin
                    if (load_of[best] != LOAD_MAX)
                        load_of[best] = load_of[best] + 1'b1;
                    move.assigned   = 1'b1;
                    move.chosen_car = CAR_ID_W'(best + 1);
                    move.move_floor = b.target_floor;
                end
                expected_moves.push_back(move);
            end
            default: ;
        endcase
    endfunction

    function automatic void flag(input string what, input t_out want, input t_out got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display({"%0t: %s: expected assigned=%0b car=%0d floor=%0d, ",
                      "got assigned=%0b car=%0d floor=%0d"},
                     $time, what, want.assigned, want.chosen_car, want.move_floor,
                     got.assigned, got.chosen_car, got.move_floor);
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CARS; i++) begin
                floor_at[i]  = '0;
                load_of[i]   = '0;
                health_of[i] = HEALTH_OK;
                warned[i]    = 1'b0;
                warn_age[i]  = '0;
            end
            cars_in_service = RST_NUM_CARS;
            capacity        = RST_CAPACITY;
            hold_ticks      = RST_HOLD;
            expected_moves.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NUM_CARS:  cars_in_service = i_cfg_data[CAR_ID_W-1:0];
                    CFG_CAPACITY:  capacity        = i_cfg_data[LOAD_W-1:0];
                    CFG_WARN_HOLD: hold_ticks      = i_cfg_data[AGE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                apply_dispatch_beat(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (expected_moves.size() == 0) begin
                    flag("result beat with nothing outstanding", '0, i_out_data);
                end else begin
                    want = expected_moves.pop_front();
                    compared++;
                    if (i_out_data.assigned   !== want.assigned   ||
                        i_out_data.chosen_car !== want.chosen_car ||
                        i_out_data.move_floor !== want.move_floor)
                        flag("move mismatch", want, i_out_data);
                end
            end
        end
        o_pending   <= expected_moves.size();
        o_err_count <= mismatches;
        o_checked   <= compared;
    end

endmodule

// File: verif/nearest_free_car_dispatcher_top_tb.sv
`timescale 1ns / 1ps

module nearest_free_car_dispatcher_top_tb;
    import nfcd_pkg::*;

    // phases of random traffic, each under its own settings
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 80;
    // room for a trailing request to scan every car and commit, with margin
    localparam int SETTLE_CYCLES   = 16;
    // far beyond the longest quiet stretch of a correct run
    localparam int STALL_LIMIT     = 4000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = '1;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in                   in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out                  out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int err_count;
    int pending;
    int checked;

    // calm: no gaps on either side for the current stretch
    bit                  calm       = 1'b0;
    logic [CAR_ID_W-1:0] cur_num    = 4'd8;
    int                  n_items    = 0;
    int                  n_requests = 0;
    int                  n_cfg      = 0;
    int                  quiet_cycles = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    nearest_free_car_dispatcher_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    nfcd_move_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_err_count (err_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Floors: a quarter land on a coarse grid so that ties turn up often.
    function automatic logic [FLOOR_BITS-1:0] pick_floor();
        if ($urandom_range(0, 3) == 0)
            return FLOOR_BITS'($urandom_range(0, 3) * 85);
        return FLOOR_BITS'($urandom);
    endfunction

    function automatic t_in beat(input logic [ACT_W-1:0]      act,
                                 input logic [CAR_ID_W-1:0]   id,
                                 input logic [FLOOR_BITS-1:0] cf,
                                 input logic [FLOOR_BITS-1:0] rf,
                                 input logic [FLOOR_BITS-1:0] tf);
        t_in b;
        b.action        = act;
        b.car_id        = id;
        b.car_floor     = cf;
        b.request_floor = rf;
        b.target_floor  = tf;
        return b;
    endfunction

    // Random beat: requests and status updates dominate so that loads keep
    // filling and draining; most car numbers hit cars that are in service.
    function automatic t_in random_beat();
        t_in b;
        int  r;
        int  hi;
        r  = $urandom_range(0, 99);
        hi = (cur_num == 0) ? 1 : ((cur_num > MAX_CARS) ? MAX_CARS : int'(cur_num));
        if (r < 32)
            b.action = ACT_REQUEST;
        else if (r < 60)
            b.action = ACT_STATUS;
        else if (r < 68)
            b.action = ACT_FAULT;
        else if (r < 76)
            b.action = ACT_WARNING;
        else if (r < 95)
            b.action = ACT_TICK;
        else
            b.action = ACT_W'($urandom_range(int'(ACT_TICK) + 1, (1 << ACT_W) - 1));
        r = $urandom_range(0, 99);
        if (r < 75)
            b.car_id = CAR_ID_W'($urandom_range(1, hi));
        else if (r < 90)
            b.car_id = CAR_ID_W'($urandom_range(1, MAX_CARS));
        else
            b.car_id = CAR_ID_W'($urandom);
        b.car_floor     = pick_floor();
        b.request_floor = pick_floor();
        b.target_floor  = FLOOR_BITS'($urandom);
        return b;
    endfunction

    // One input beat, with a random gap ahead of it. Valid is only dropped
    // when there is a gap, so back-to-back beats keep it high.
    task automatic send(input t_in b);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (!in_ready);
        n_items++;
        if (b.action == ACT_REQUEST)
            n_requests++;
    endtask

    // Drain all outstanding moves, then let any trailing event finish.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        n_cfg++;
    endtask

    // Writes every register, plus the spare index, with noise in the unused
    // upper bits of the narrow ones. Called only with the block idle.
    task automatic program_settings(input logic [CAR_ID_W-1:0] num_v,
                                    input logic [LOAD_W-1:0]   cap_v,
                                    input logic [AGE_W-1:0]    hold_v);
        cfg_beat(CFG_NUM_CARS,  {12'($urandom), num_v});
        cfg_beat(CFG_CAPACITY,  {12'($urandom), cap_v});
        cfg_beat(CFG_WARN_HOLD, hold_v);
        cfg_beat(CFG_SPARE,     CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        cur_num = num_v;
    endtask

    // Result side: random stalls, none while calm.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (calm || stall_left == 0) begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end else begin
                out_ready <= 1'b0;
                stall_left--;
            end
        end
    end

    // Watchdog: any accepted beat on any channel counts as progress.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles, %0d moves outstanding",
                     quiet_cycles, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        logic [CAR_ID_W-1:0] num_v;
        logic [LOAD_W-1:0]   cap_v;
        logic [AGE_W-1:0]    hold_v;
        int                  r;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed beats under reset settings (8 cars, capacity 4, hold 5) ---
        // every car at floor 0: tie goes to car 1, top target floor
        send(beat(ACT_REQUEST, 4'd1, 8'h00, 8'h00, 8'hFF));
        send(beat(ACT_STATUS,  4'd8, 8'hFF, 8'h00, 8'h00));
        send(beat(ACT_STATUS,  4'd1, 8'd128, 8'hFF, 8'hFF));   // also drains car 1
        // car numbers zero and beyond the largest fleet are ignored
        send(beat(ACT_STATUS,  4'd0, 8'd7, 8'd7, 8'd7));
        send(beat(ACT_STATUS,  4'hF, 8'd9, 8'd9, 8'd9));
        send(beat(ACT_FAULT,   4'd9, 8'hFF, 8'hFF, 8'hFF));
        // top floor: car 8 sits there
        send(beat(ACT_REQUEST, 4'd0, 8'h00, 8'hFF, 8'h00));
        // faulted car 8 is skipped, car 1 at mid height is nearest
        send(beat(ACT_FAULT,   4'd8, 8'h00, 8'h00, 8'h00));
        send(beat(ACT_REQUEST, 4'd8, 8'h00, 8'hFF, 8'hA5));
        // never warned: status clears the fault
        send(beat(ACT_STATUS,  4'd8, 8'd200, 8'h00, 8'h00));
        // warning on car 2 survives status until its age passes the hold
        send(beat(ACT_WARNING, 4'd2, 8'h00, 8'h00, 8'h00));
        send(beat(ACT_TICK,    4'd0, 8'h00, 8'h00, 8'h00));
        send(beat(ACT_STATUS,  4'd2, 8'd3, 8'h00, 8'h00));
        repeat (4) send(beat(ACT_TICK, 4'd0, 8'h00, 8'h00, 8'h00));
        send(beat(ACT_STATUS,  4'd2, 8'd3, 8'h00, 8'h00));      // age equals hold: kept
        send(beat(ACT_REQUEST, 4'd0, 8'h00, 8'd3, 8'h11));
        send(beat(ACT_TICK,    4'd0, 8'h00, 8'h00, 8'h00));
        send(beat(ACT_STATUS,  4'd2, 8'd3, 8'h00, 8'h00));      // age past hold: cleared
        send(beat(ACT_REQUEST, 4'd0, 8'h00, 8'd3, 8'h22));
        // spare action codes do nothing
        for (int k = int'(ACT_TICK) + 1; k < (1 << ACT_W); k++)
            send(beat(ACT_W'(k), 4'd1, 8'h55, 8'hAA, 8'h5A));
        send(beat(ACT_REQUEST, 4'd0, 8'h00, 8'd128, 8'h5A));

        // --- random phases, each under fresh settings ---
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            case (ph)
                0: begin num_v = 4'd1; cap_v = 4'd1;  hold_v = 16'd0;  end
                1: begin num_v = 4'd8; cap_v = 4'd15; hold_v = AGE_MAX; end
                2: begin num_v = 4'd0; cap_v = 4'd4;  hold_v = 16'd3;  end   // empty fleet
                3: begin num_v = 4'd8; cap_v = 4'd0;  hold_v = 16'd2;  end   // zero capacity
                4: begin num_v = 4'hF; cap_v = 4'd3;  hold_v = 16'd1;  end   // count clipped
                default: begin
                    r = $urandom_range(0, 9);
                    num_v = (r == 0) ? 4'd0 : (r == 1) ? 4'd1 : (r == 2) ? 4'd8 :
                            (r == 3) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
                    r = $urandom_range(0, 9);
                    cap_v = (r == 0) ? 4'd1 : (r == 1) ? 4'd15 : 4'($urandom_range(1, 6));
                    r = $urandom_range(0, 9);
                    hold_v = (r == 0) ? 16'd0 : (r == 1) ? AGE_MAX :
                             (r == 2) ? 16'($urandom) : 16'($urandom_range(0, 8));
                end
            endcase
            program_settings(num_v, cap_v, hold_v);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // occasional stretches with no gaps on either side
                if (n % 20 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                send(random_beat());
            end
        end

        settle();
        $display("Run covered %0d input beats (%0d ride requests) and %0d register writes,",
                 n_items, n_requests, n_cfg);
        $display("with %0d result beats compared across edge-case and random settings.",
                 checked);
        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
